FILE: rtl/tmm_pkg.sv
// Shared types, constants and codes of the triangular matrix multiply engine.
package tmm_pkg;

    // Matrix geometry.
    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = IDX_W + 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;

    // Item opcodes.
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_READ_C  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_RIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_TRIANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_DIAGONAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_BITS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N         = 3'd6;

    // Single-precision constants.
    localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO   = 32'h0000_0000;
    localparam logic [31:0] FP_QNAN   = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET  = 32'h0040_0000;
    localparam int          FP_MW     = 50;

    // Configuration register set.
    typedef struct packed {
        logic                 side_right;
        logic                 upper_triangle;
        logic                 transpose_a;
        logic                 unit_diagonal;
        logic [31:0]          alpha_bits;
        logic [DIM_W-1:0]     rows_m;
        logic [DIM_W-1:0]     cols_n;
    } cfg_t;

    // One queued item.
    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [31:0]      value_bits;
    } item_t;

    // Request to and response from the floating-point unit.
    typedef struct packed {
        logic        start;
        logic        is_add;
        logic [31:0] op_a;
        logic [31:0] op_b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    // Sequencer states of the back end.
    typedef enum logic [3:0] {
        B_IDLE,
        B_ISSUE,
        B_MUL,
        B_MWAIT,
        B_ADD,
        B_AWAIT,
        B_SCALE,
        B_SWAIT,
        B_OUT
    } back_state_t;

endpackage

FILE: rtl/tmm_front.sv
// Front end: accepts input items, drops unused opcodes and queues the rest.
module tmm_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_opcode,
    input  logic [tmm_pkg::IDX_W-1:0]  s_row,
    input  logic [tmm_pkg::IDX_W-1:0]  s_col,
    input  logic [31:0]                s_value_bits,
    output logic                       q_valid,
    output tmm_pkg::item_t             q_item,
    input  logic                       q_ready
);
    import tmm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    logic       useful;

    // Only writes and reads carry work; the unused opcode is taken and dropped.
    always_comb begin
        useful  = (s_opcode == OP_WRITE_A) || (s_opcode == OP_WRITE_B) ||
                  (s_opcode == OP_READ_C);
        s_ready = (count_reg != 2'd2);
        push    = s_valid && s_ready && useful;
        q_valid = (count_reg != 2'd0);
        q_item  = slot_reg[rd_ptr_reg];
        pop     = q_valid && q_ready;
    end

    // Queue payload.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{opcode: s_opcode, row: s_row, col: s_col,
                                      value_bits: s_value_bits};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: rtl/tmm_fpu.sv
// Shared single-precision multiply and add unit.
module tmm_fpu (
    input  logic              aclk,
    input  logic              aresetn,
    input  tmm_pkg::fpu_req_t req,
    output tmm_pkg::fpu_rsp_t rsp
);
    import tmm_pkg::*;

    // Stage 1 registers.
    logic                    v1_reg;
    logic                    sign1_reg;
    logic                    spec1_reg;
    logic [31:0]             specv1_reg;
    logic [FP_MW-1:0]        m1_reg;
    logic signed [10:0]      eb1_reg;
    // Stage 2 registers.
    logic                    v2_reg;
    logic                    sign2_reg;
    logic                    spec2_reg;
    logic [31:0]             specv2_reg;
    logic [FP_MW-1:0]        m2_reg;
    logic signed [10:0]      e2_reg;
    // Stage 3 registers.
    logic                    done_reg;
    logic [31:0]             res_reg;

    // Stage 1 combinational values.
    logic                    sa, sb;
    logic [7:0]              ea, eb;
    logic [22:0]             fa, fb;
    logic                    a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0]             ma, mb;
    logic [7:0]              eae, ebe;
    logic [47:0]             prod;
    logic                    a_big;
    logic [7:0]              e_big, e_small;
    logic [23:0]             m_big, m_small;
    logic [7:0]              dsh;
    logic [FP_MW-1:0]        big_w, small_w, small_sh;
    logic                    sticky;
    logic [FP_MW-1:0]        sum_w;
    logic                    sign1_c, spec1_c;
    logic [31:0]             specv1_c;
    logic [FP_MW-1:0]        m1_c;
    logic signed [10:0]      eb1_c;

    // Stage 2 combinational values.
    logic [5:0]              lz;
    logic                    found;

    // Stage 3 combinational values.
    logic [6:0]              sh;
    logic [63:0]             wide, shifted;
    logic                    lost;
    logic [22:0]             mant;
    logic                    guard, stk;
    logic [7:0]              ef;
    logic [30:0]             packed_v;
    logic [31:0]             res_c;

    // Unpack, handle special operands, multiply or align and add.
    always_comb begin
        sa = req.op_a[31]; ea = req.op_a[30:23]; fa = req.op_a[22:0];
        sb = req.op_b[31]; eb = req.op_b[30:23]; fb = req.op_b[22:0];
        a_nan  = (ea == 8'hFF) && (fa != 23'd0);
        b_nan  = (eb == 8'hFF) && (fb != 23'd0);
        a_inf  = (ea == 8'hFF) && (fa == 23'd0);
        b_inf  = (eb == 8'hFF) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        ma  = {ea != 8'd0, fa};
        mb  = {eb != 8'd0, fb};
        eae = (ea == 8'd0) ? 8'd1 : ea;
        ebe = (eb == 8'd0) ? 8'd1 : eb;
        prod = ma * mb;

        // Alignment for the add path: larger magnitude first.
        a_big   = (req.op_a[30:0] >= req.op_b[30:0]);
        e_big   = a_big ? eae : ebe;
        e_small = a_big ? ebe : eae;
        m_big   = a_big ? ma : mb;
        m_small = a_big ? mb : ma;
        dsh     = e_big - e_small;
        big_w   = {1'b0, m_big, 25'd0};
        small_w = {1'b0, m_small, 25'd0};
        if (dsh >= 8'(FP_MW)) begin
            small_sh = '0;
            sticky   = (m_small != 24'd0);
        end else begin
            small_sh = small_w >> dsh;
            sticky   = ((small_sh << dsh) != small_w);
        end
        sum_w = (sa ^ sb) ? (big_w - (small_sh | FP_MW'(sticky)))
                          : (big_w + (small_sh | FP_MW'(sticky)));

        spec1_c  = 1'b0;
        specv1_c = FP_ZERO;
        if (req.is_add) begin
            sign1_c = a_big ? sa : sb;
            m1_c    = sum_w;
            eb1_c   = 11'(e_big) + 11'sd1;
            if (a_nan) begin
                spec1_c = 1'b1; specv1_c = req.op_a | FP_QUIET;
            end else if (b_nan) begin
                spec1_c = 1'b1; specv1_c = req.op_b | FP_QUIET;
            end else if (a_inf && b_inf && (sa != sb)) begin
                spec1_c = 1'b1; specv1_c = FP_QNAN;
            end else if (a_inf) begin
                spec1_c = 1'b1; specv1_c = req.op_a;
            end else if (b_inf) begin
                spec1_c = 1'b1; specv1_c = req.op_b;
            end else if (sum_w == '0) begin
                spec1_c = 1'b1; specv1_c = {sa & sb, 31'd0};
            end
        end else begin
            sign1_c = sa ^ sb;
            m1_c    = {prod, 2'b00};
            eb1_c   = 11'(eae) + 11'(ebe) - 11'sd126;
            if (a_nan) begin
                spec1_c = 1'b1; specv1_c = req.op_a | FP_QUIET;
            end else if (b_nan) begin
                spec1_c = 1'b1; specv1_c = req.op_b | FP_QUIET;
            end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                spec1_c = 1'b1; specv1_c = FP_QNAN;
            end else if (a_inf || b_inf) begin
                spec1_c = 1'b1; specv1_c = {sa ^ sb, 8'hFF, 23'd0};
            end else if (a_zero || b_zero) begin
                spec1_c = 1'b1; specv1_c = {sa ^ sb, 31'd0};
            end
        end
    end

    // Leading-zero count of the stage 1 magnitude.
    always_comb begin
        lz    = '0;
        found = 1'b0;
        for (int i = FP_MW - 1; i >= 0; i--) begin
            if (!found && m1_reg[i]) begin
                lz    = 6'(FP_MW - 1 - i);
                found = 1'b1;
            end
        end
    end

    // Denormalize if needed and round to nearest even.
    always_comb begin
        if (e2_reg < -11'sd62) begin
            sh = 7'd63;
        end else begin
            sh = 7'(11'sd1 - e2_reg);
        end
        wide    = 64'(m2_reg);
        shifted = wide >> sh;
        lost    = ((shifted << sh) != wide);
        if (e2_reg >= 11'sd1) begin
            mant  = m2_reg[48:26];
            guard = m2_reg[25];
            stk   = |m2_reg[24:0];
            ef    = e2_reg[7:0];
        end else begin
            mant  = shifted[48:26];
            guard = shifted[25];
            stk   = (|shifted[24:0]) | lost;
            ef    = 8'd0;
        end
        packed_v = {ef, mant} + 31'(guard & (stk | mant[0]));
        if (spec2_reg) begin
            res_c = specv2_reg;
        end else if (e2_reg >= 11'sd255) begin
            res_c = {sign2_reg, 8'hFF, 23'd0};
        end else begin
            res_c = {sign2_reg, packed_v};
        end
    end

    // Stage payload registers.
    always_ff @(posedge aclk) begin
        sign1_reg  <= sign1_c;
        spec1_reg  <= spec1_c;
        specv1_reg <= specv1_c;
        m1_reg     <= m1_c;
        eb1_reg    <= eb1_c;
        sign2_reg  <= sign1_reg;
        spec2_reg  <= spec1_reg;
        specv2_reg <= specv1_reg;
        m2_reg     <= m1_reg << lz;
        e2_reg     <= eb1_reg - 11'(lz);
        if (v2_reg) res_reg <= res_c;
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    assign rsp = '{done: done_reg, result: res_reg};

endmodule

FILE: rtl/tmm_back.sv
// Back end: element stores, dot-product sequencer and result register.
module tmm_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tmm_pkg::cfg_t              cfg,
    input  logic                       q_valid,
    input  tmm_pkg::item_t             q_item,
    output logic                       q_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [31:0]                m_c_bits,
    output logic [tmm_pkg::IDX_W-1:0]  m_out_row,
    output logic [tmm_pkg::IDX_W-1:0]  m_out_col
);
    import tmm_pkg::*;

    logic [31:0]      a_mem [MEM_DEPTH];
    logic [31:0]      b_mem [MEM_DEPTH];
    logic [31:0]      a_rd_reg, b_rd_reg;

    back_state_t      state_reg, state_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [31:0]      sum_reg, sum_next;
    logic [31:0]      c_reg, c_next;
    logic             unit_hit_reg, unit_hit_next;
    logic             inside_reg, inside_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_c_reg, m_c_next;
    logic [IDX_W-1:0] m_row_reg, m_row_next, m_col_reg, m_col_next;

    logic             a_we, b_we, rd_en;
    logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;
    logic [DIM_W-1:0] m_dim, n_dim, k_dim;
    logic [IDX_W-1:0] k_idx, er, ec, ai, aj;
    logic [31:0]      a_eff;
    fpu_req_t         fpu_req;
    fpu_rsp_t         fpu_rsp;

    tmm_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .rsp     (fpu_rsp)
    );

    // Element stores: one write port and one registered read port each.
    always_ff @(posedge aclk) begin
        if (a_we) a_mem[wr_addr] <= q_item.value_bits;
        if (b_we) b_mem[wr_addr] <= q_item.value_bits;
        if (rd_en) begin
            a_rd_reg <= a_mem[a_addr];
            b_rd_reg <= b_mem[b_addr];
        end
    end

    // Dimensions, element positions and the effective A element.
    always_comb begin
        m_dim = (cfg.rows_m == '0) ? DIM_W'(1) :
                (cfg.rows_m > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.rows_m;
        n_dim = (cfg.cols_n == '0) ? DIM_W'(1) :
                (cfg.cols_n > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.cols_n;
        k_dim = cfg.side_right ? n_dim : m_dim;
        k_idx = k_reg[IDX_W-1:0];
        er    = cfg.side_right ? k_idx : row_reg;
        ec    = cfg.side_right ? col_reg : k_idx;
        ai    = cfg.transpose_a ? ec : er;
        aj    = cfg.transpose_a ? er : ec;
        a_addr  = {ai, aj};
        b_addr  = cfg.side_right ? {row_reg, k_idx} : {k_idx, col_reg};
        wr_addr = {q_item.row, q_item.col};
        a_eff = unit_hit_reg ? FP_ONE : (inside_reg ? a_rd_reg : FP_ZERO);
    end

    // Sequencer: next state and datapath controls.
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        sum_next      = sum_reg;
        c_next        = c_reg;
        unit_hit_next = unit_hit_reg;
        inside_next   = inside_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_c_next      = m_c_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        a_we          = 1'b0;
        b_we          = 1'b0;
        rd_en         = 1'b0;
        q_ready       = (state_reg == B_IDLE);
        fpu_req       = '{start: 1'b0, is_add: 1'b0, op_a: a_eff, op_b: b_rd_reg};

        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    a_we     = (q_item.opcode == OP_WRITE_A);
                    b_we     = (q_item.opcode == OP_WRITE_B);
                    row_next = q_item.row;
                    col_next = q_item.col;
                    k_next   = '0;
                    if (q_item.opcode == OP_READ_C) begin
                        if ({1'b0, q_item.row} >= m_dim || {1'b0, q_item.col} >= n_dim) begin
                            c_next     = FP_ZERO;
                            state_next = B_OUT;
                        end else begin
                            state_next = B_ISSUE;
                        end
                    end
                end
            end
            B_ISSUE: begin
                rd_en         = 1'b1;
                unit_hit_next = cfg.unit_diagonal && (er == ec);
                inside_next   = cfg.upper_triangle ? (ai <= aj) : (ai >= aj);
                state_next    = B_MUL;
            end
            B_MUL: begin
                fpu_req.start = 1'b1;
                fpu_req.op_a  = cfg.side_right ? b_rd_reg : a_eff;
                fpu_req.op_b  = cfg.side_right ? a_eff : b_rd_reg;
                state_next    = B_MWAIT;
            end
            B_MWAIT: begin
                if (fpu_rsp.done) begin
                    if (k_reg == '0) begin
                        sum_next = fpu_rsp.result;
                        if (k_reg + DIM_W'(1) == k_dim) begin
                            state_next = B_SCALE;
                        end else begin
                            k_next     = k_reg + DIM_W'(1);
                            state_next = B_ISSUE;
                        end
                    end else begin
                        state_next = B_ADD;
                    end
                end
            end
            B_ADD: begin
                fpu_req.start  = 1'b1;
                fpu_req.is_add = 1'b1;
                fpu_req.op_a   = sum_reg;
                fpu_req.op_b   = fpu_rsp.result;
                state_next     = B_AWAIT;
            end
            B_AWAIT: begin
                if (fpu_rsp.done) begin
                    sum_next = fpu_rsp.result;
                    if (k_reg + DIM_W'(1) == k_dim) begin
                        state_next = B_SCALE;
                    end else begin
                        k_next     = k_reg + DIM_W'(1);
                        state_next = B_ISSUE;
                    end
                end
            end
            B_SCALE: begin
                fpu_req.start = 1'b1;
                fpu_req.op_a  = cfg.alpha_bits;
                fpu_req.op_b  = sum_reg;
                state_next    = B_SWAIT;
            end
            B_SWAIT: begin
                if (fpu_rsp.done) begin
                    c_next     = fpu_rsp.result;
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_c_next     = c_reg;
                    m_row_next   = row_reg;
                    m_col_next   = col_reg;
                    state_next   = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Sequencer payload registers.
    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        sum_reg      <= sum_next;
        c_reg        <= c_next;
        unit_hit_reg <= unit_hit_next;
        inside_reg   <= inside_next;
        m_c_reg      <= m_c_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
    end

    // Sequencer state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_c_bits  = m_c_reg;
    assign m_out_row = m_row_reg;
    assign m_out_col = m_col_reg;

endmodule

FILE: rtl/triangular_matrix_multiply_top.sv
// Top level of the single-precision triangular matrix multiply engine.
//
// Input items arrive on the s_ channel (valid/ready). Opcode write A and
// write B store one element of A or B; read C returns one element of
// C = alpha*op(A)*B or alpha*B*op(A) on the m_ channel; the unused opcode
// is taken and dropped. Configuration registers are written through
// cfg_wen/cfg_addr/cfg_wdata; the user must write them only while no
// item is in flight, and the block itself does not enforce this. Each
// write or read transfer first lands in a two-entry queue, so the input
// side keeps taking items while the back end computes or the receiver
// stalls. A write is stored in the same cycle it leaves the queue. A read
// walks k = 0 .. K-1 through one shared floating-point unit: each term
// reads its A and B elements and multiplies them, each later term's
// product is then added to the running sum; then come the alpha scale and
// hand-off to the result register. Out-of-range reads return zero.
// A stalled receiver holds the result register; the back end then waits,
// and once the queue is full s_ready drops.
// Synchronous reset (aresetn low) empties the queue, idles the sequencer
// and restores the register defaults; the element stores are not cleared.
module triangular_matrix_multiply_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [tmm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [tmm_pkg::IDX_W-1:0]     s_row,
    input  logic [tmm_pkg::IDX_W-1:0]     s_col,
    input  logic [31:0]                   s_value_bits,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_c_bits,
    output logic [tmm_pkg::IDX_W-1:0]     m_out_row,
    output logic [tmm_pkg::IDX_W-1:0]     m_out_col
);
    import tmm_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{side_right: 1'b0, upper_triangle: 1'b1, transpose_a: 1'b0,
                         unit_diagonal: 1'b0, alpha_bits: FP_ONE,
                         rows_m: DIM_W'(MAX_DIM), cols_n: DIM_W'(MAX_DIM)};
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                CFG_SIDE_RIGHT:     cfg_reg.side_right     <= cfg_wdata[0];
                CFG_UPPER_TRIANGLE: cfg_reg.upper_triangle <= cfg_wdata[0];
                CFG_TRANSPOSE_A:    cfg_reg.transpose_a    <= cfg_wdata[0];
                CFG_UNIT_DIAGONAL:  cfg_reg.unit_diagonal  <= cfg_wdata[0];
                CFG_ALPHA_BITS:     cfg_reg.alpha_bits     <= cfg_wdata;
                CFG_ROWS_M:         cfg_reg.rows_m         <= cfg_wdata[DIM_W-1:0];
                CFG_COLS_N:         cfg_reg.cols_n         <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    tmm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_value_bits (s_value_bits),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_ready      (q_ready)
    );

    tmm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_ready   (q_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_c_bits  (m_c_bits),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col)
    );

endmodule

FILE: rtl/tmm_checker.sv
// Port-level checker of the triangular matrix multiply engine and its bind.
module tmm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [1:0]                    s_opcode,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [31:0]                   m_c_bits,
    input logic [tmm_pkg::IDX_W-1:0]     m_out_row,
    input logic [tmm_pkg::IDX_W-1:0]     m_out_col
);
    import tmm_pkg::*;

    logic [2:0] pending_reg;
    logic       rd_in;
    logic       rd_out;

    // Reads accepted whose result transfer is still to come.
    assign rd_in  = s_valid && s_ready && (s_opcode == OP_READ_C);
    assign rd_out = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
        end else begin
            pending_reg <= pending_reg + {2'b00, rd_in} - {2'b00, rd_out};
        end
    end

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result keeps its value and position.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_c_bits) &&
                                $stable(m_out_row) && $stable(m_out_col))
        else $error("stalled result changed");

    // Every result answers an earlier read.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result without an outstanding read");

    // At most queue depth plus sequencer plus result register reads in flight.
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd4)
        else $error("too many reads in flight");

endmodule

bind triangular_matrix_multiply_top tmm_checker u_tmm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_opcode  (s_opcode),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_c_bits  (m_c_bits),
    .m_out_row (m_out_row),
    .m_out_col (m_out_col)
);
